// ===== hdl/rpt_pkg.sv =====
// Shared types and constants of the ranked population table.
// No dependencies; every other file of the block depends on this package.
package rpt_pkg;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_SCORE_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LARGER_IS_BETTER = 1'b0,
        CFG_CAPACITY_LIMIT   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_REMOVE,
        CELL_COMPARE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     larger_is_better;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PREFIX,
        ST_REMOVE,
        ST_COMPARE,
        ST_SCAN,
        ST_INSERT,
        ST_REPORT
    } state_t;

endpackage

// ===== hdl/rpt_if.sv =====
// Channel interfaces of the ranked population table: score requests,
// results and configuration writes. Depends on rpt_pkg for default widths.
interface rpt_score_if #(
    parameter int SCORE_BITS = rpt_pkg::DEF_SCORE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] score;

    modport source (output valid, output score, input ready);
    modport sink (input valid, input score, output ready);
endinterface

interface rpt_result_if #(
    parameter int SLOT_BITS  = $clog2(rpt_pkg::DEF_CAPACITY),
    parameter int COUNT_BITS = $clog2(rpt_pkg::DEF_CAPACITY + 1),
    parameter int SCORE_BITS = rpt_pkg::DEF_SCORE_BITS
);
    logic                         valid;
    logic                         ready;
    logic [SLOT_BITS-1:0]         slot;
    logic [SLOT_BITS-1:0]         rank;
    logic                         evicted;
    logic [COUNT_BITS-1:0]        fill_count;
    logic [SLOT_BITS-1:0]         best_slot;
    logic signed [SCORE_BITS-1:0] best_score;

    modport source (output valid, output slot, output rank, output evicted,
                     output fill_count, output best_slot, output best_score,
                     input ready);
    modport sink (input valid, input slot, input rank, input evicted,
                   input fill_count, input best_slot, input best_score,
                   output ready);
endinterface

interface rpt_cfg_if #(
    parameter int INDEX_BITS = rpt_pkg::CFG_INDEX_BITS,
    parameter int DATA_BITS  = $clog2(rpt_pkg::DEF_CAPACITY + 1)
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ranked_population_table_unit.sv =====
// Top level of the ranked population table: control, configuration, rover,
// output register and the row of rank cells. Depends on rpt_pkg, rpt_if,
// rpt_cell and rpt_prefix.
//
//   Channel  Direction  Fields
//   item     sink       score
//   result   source     slot, rank, evicted, fill_count, best_slot, best_score
//   cfg      sink       index, data (always ready)
//
// A request whose slot is free runs the compare, a prefix step, the insert
// shift and the rank encode; when the slot's old member is removed first,
// match, a prefix step and the removal shift in the cell row come before.
// Reset clears the fill count, rover and registers; cell contents need none.
// The result waits in an output register while the next request is taken;
// the report step holds until the previous result has been taken.
module ranked_population_table_unit #(
    parameter int CAPACITY   = rpt_pkg::DEF_CAPACITY,
    parameter int SCORE_BITS = rpt_pkg::DEF_SCORE_BITS
) (
    input logic          clk,
    input logic          rst_n,
    rpt_score_if.sink    item,
    rpt_result_if.source result,
    rpt_cfg_if.sink      cfg
);
    import rpt_pkg::*;

    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(CAPACITY);
    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    state_t                       state_reg, state_next;
    logic signed [SCORE_BITS-1:0] score_in_reg, score_in_next;
    logic [SLOT_BITS-1:0]         slot_cur_reg, slot_cur_next;
    logic                         evict_reg, evict_next;
    logic [SLOT_BITS-1:0]         rover_reg, rover_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic                         lib_reg, lib_next;
    logic [COUNT_BITS-1:0]        cap_reg, cap_next;

    logic                         out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0]         out_slot_reg, out_slot_next;
    logic [SLOT_BITS-1:0]         out_rank_reg, out_rank_next;
    logic                         out_evicted_reg, out_evicted_next;
    logic [COUNT_BITS-1:0]        out_fill_reg, out_fill_next;
    logic [SLOT_BITS-1:0]         out_best_slot_reg, out_best_slot_next;
    logic signed [SCORE_BITS-1:0] out_best_score_reg, out_best_score_next;

    logic [COUNT_BITS-1:0]        limit;
    logic [SLOT_BITS-1:0]         slot_pick;
    logic [COUNT_BITS-1:0]        slot_plus;
    logic                         evict_pick;
    logic [SLOT_BITS-1:0]         rank_enc;
    cell_ctrl_t                   ctrl;

    logic signed [SCORE_BITS-1:0] cell_score [CAPACITY];
    logic [SLOT_BITS-1:0]         cell_slot  [CAPACITY];
    logic [CAPACITY-1:0]          match_flags;
    logic [CAPACITY-1:0]          ins_flags;
    logic [CAPACITY-1:0]          covered;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            limit = ONE;
        end
        else if (cap_reg > CAP)
        begin
            limit = CAP;
        end
        else
        begin
            limit = cap_reg;
        end
        slot_pick  = ({1'b0, rover_reg} < limit) ? rover_reg : '0;
        slot_plus  = {1'b0, slot_pick} + ONE;
        evict_pick = {1'b0, slot_pick} < count_reg;
    end

    always_comb
    begin
        rank_enc = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (ins_flags[k])
            begin
                rank_enc = rank_enc | SLOT_BITS'(k);
            end
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        score_in_next       = score_in_reg;
        slot_cur_next       = slot_cur_reg;
        evict_next          = evict_reg;
        rover_next          = rover_reg;
        count_next          = count_reg;
        lib_next            = lib_reg;
        cap_next            = cap_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        out_slot_next       = out_slot_reg;
        out_rank_next       = out_rank_reg;
        out_evicted_next    = out_evicted_reg;
        out_fill_next       = out_fill_reg;
        out_best_slot_next  = out_best_slot_reg;
        out_best_score_next = out_best_score_reg;
        ctrl.op               = CELL_HOLD;
        ctrl.larger_is_better = lib_reg;
        item.ready            = 1'b0;
        cfg.ready             = 1'b1;

        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_LARGER_IS_BETTER: lib_next = cfg.data[0];
                CFG_CAPACITY_LIMIT:   cap_next = cfg.data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    score_in_next = item.score;
                    slot_cur_next = slot_pick;
                    evict_next    = evict_pick;
                    rover_next    = (slot_plus >= limit) ? '0 : slot_plus[SLOT_BITS-1:0];
                    state_next    = evict_pick ? ST_MATCH : ST_COMPARE;
                end
            end
            ST_MATCH:
            begin
                ctrl.op    = CELL_MATCH;
                state_next = ST_PREFIX;
            end
            ST_PREFIX:
            begin
                state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                ctrl.op    = CELL_REMOVE;
                count_next = count_reg - ONE;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                ctrl.op    = CELL_COMPARE;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                ctrl.op    = CELL_INSERT;
                count_next = count_reg + ONE;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_slot_next       = slot_cur_reg;
                    out_rank_next       = rank_enc;
                    out_evicted_next    = evict_reg;
                    out_fill_next       = count_reg;
                    out_best_slot_next  = cell_slot[0];
                    out_best_score_next = cell_score[0];
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rover_reg     <= '0;
            count_reg     <= '0;
            lib_reg       <= 1'b0;
            cap_reg       <= CAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            count_reg     <= count_next;
            lib_reg       <= lib_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_in_reg       <= score_in_next;
        slot_cur_reg       <= slot_cur_next;
        evict_reg          <= evict_next;
        out_slot_reg       <= out_slot_next;
        out_rank_reg       <= out_rank_next;
        out_evicted_reg    <= out_evicted_next;
        out_fill_reg       <= out_fill_next;
        out_best_slot_reg  <= out_best_slot_next;
        out_best_score_reg <= out_best_score_next;
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [SCORE_BITS-1:0] prev_score;
        logic [SLOT_BITS-1:0]         prev_slot;
        logic                         prev_cover;
        logic signed [SCORE_BITS-1:0] next_score;
        logic [SLOT_BITS-1:0]         next_slot;

        if (k == 0)
        begin : g_first
            assign prev_score = '0;
            assign prev_slot  = '0;
            assign prev_cover = 1'b0;
        end
        else
        begin : g_inner_prev
            assign prev_score = cell_score[k-1];
            assign prev_slot  = cell_slot[k-1];
            assign prev_cover = covered[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign next_score = '0;
            assign next_slot  = '0;
        end
        else
        begin : g_inner_next
            assign next_score = cell_score[k+1];
            assign next_slot  = cell_slot[k+1];
        end

        rpt_cell #(
            .SCORE_BITS (SCORE_BITS),
            .SLOT_BITS  (SLOT_BITS),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .new_score  (score_in_reg),
            .new_slot   (slot_cur_reg),
            .prev_score (prev_score),
            .prev_slot  (prev_slot),
            .prev_cover (prev_cover),
            .next_score (next_score),
            .next_slot  (next_slot),
            .shift_up   (covered[k]),
            .score      (cell_score[k]),
            .slot       (cell_slot[k]),
            .match      (match_flags[k]),
            .ins        (ins_flags[k])
        );
    end

    rpt_prefix #(
        .N (CAPACITY)
    ) u_prefix (
        .clk     (clk),
        .hits    (match_flags),
        .covered (covered)
    );

    assign result.valid      = out_valid_reg;
    assign result.slot       = out_slot_reg;
    assign result.rank       = out_rank_reg;
    assign result.evicted    = out_evicted_reg;
    assign result.fill_count = out_fill_reg;
    assign result.best_slot  = out_best_slot_reg;
    assign result.best_score = out_best_score_reg;

endmodule

// ===== hdl/rpt_cell.sv =====
// One rank position of the ranked population table: holds a score and a slot
// and shifts toward its neighbors on removal and insertion. Depends on rpt_pkg.
module rpt_cell #(
    parameter int SCORE_BITS = rpt_pkg::DEF_SCORE_BITS,
    parameter int SLOT_BITS  = $clog2(rpt_pkg::DEF_CAPACITY),
    parameter int COUNT_BITS = $clog2(rpt_pkg::DEF_CAPACITY + 1),
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpt_pkg::cell_ctrl_t          ctrl,
    input  logic [COUNT_BITS-1:0]        count,
    input  logic signed [SCORE_BITS-1:0] new_score,
    input  logic [SLOT_BITS-1:0]         new_slot,
    input  logic signed [SCORE_BITS-1:0] prev_score,
    input  logic [SLOT_BITS-1:0]         prev_slot,
    input  logic                         prev_cover,
    input  logic signed [SCORE_BITS-1:0] next_score,
    input  logic [SLOT_BITS-1:0]         next_slot,
    input  logic                         shift_up,
    output logic signed [SCORE_BITS-1:0] score,
    output logic [SLOT_BITS-1:0]         slot,
    output logic                         match,
    output logic                         ins
);
    import rpt_pkg::*;

    localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(INDEX);

    logic signed [SCORE_BITS-1:0] score_reg, score_next;
    logic [SLOT_BITS-1:0]         slot_reg, slot_next;
    logic                         match_reg, match_next;
    logic                         ins_reg, ins_next;
    logic                         occupied;
    logic                         better;
    logic                         cmp;

    always_comb
    begin
        occupied   = IDX < count;
        better     = ctrl.larger_is_better ? (new_score >= score_reg)
                                           : (new_score <= score_reg);
        cmp        = !occupied || better;
        score_next = score_reg;
        slot_next  = slot_reg;
        match_next = match_reg;
        ins_next   = ins_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_MATCH:
            begin
                match_next = occupied && (slot_reg == new_slot);
            end
            CELL_REMOVE:
            begin
                if (shift_up)
                begin
                    score_next = next_score;
                    slot_next  = next_slot;
                end
            end
            CELL_COMPARE:
            begin
                match_next = cmp;
            end
            CELL_INSERT:
            begin
                ins_next = shift_up && !prev_cover;
                if (shift_up && !prev_cover)
                begin
                    score_next = new_score;
                    slot_next  = new_slot;
                end
                else if (prev_cover)
                begin
                    score_next = prev_score;
                    slot_next  = prev_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            ins_reg   <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        slot_reg  <= slot_next;
    end

    assign score = score_reg;
    assign slot  = slot_reg;
    assign match = match_reg;
    assign ins   = ins_reg;

endmodule

// ===== hdl/rpt_prefix.sv =====
// Prefix OR over the flags of the cell row, so that each cell learns whether
// the removed entry or the first place for a new score sits at or above its
// rank. Registered halfway.
module rpt_prefix #(
    parameter int N = rpt_pkg::DEF_CAPACITY
) (
    input  logic         clk,
    input  logic [N-1:0] hits,
    output logic [N-1:0] covered
);
    import rpt_pkg::*;

    localparam int LEVELS = $clog2(N);
    localparam int CUT    = LEVELS / 2;

    logic [N-1:0] lvl [0:LEVELS];

    assign lvl[0] = hits;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        logic [N-1:0] src;
        if (l == CUT)
        begin : g_cut
            logic [N-1:0] cut_reg;
            always_ff @(posedge clk)
            begin
                cut_reg <= lvl[l];
            end
            assign src = cut_reg;
        end
        else
        begin : g_pass
            assign src = lvl[l];
        end
        assign lvl[l+1] = src | (src << (1 << l));
    end

    assign covered = lvl[LEVELS];

endmodule

// ===== hdl/rpt_checker.sv =====
// Port-level checks of the ranked population table and the bind that
// attaches them to ranked_population_table_unit. Depends on rpt_pkg.
module rpt_checker #(
    parameter int CAPACITY   = rpt_pkg::DEF_CAPACITY,
    parameter int SLOT_BITS  = $clog2(rpt_pkg::DEF_CAPACITY),
    parameter int COUNT_BITS = $clog2(rpt_pkg::DEF_CAPACITY + 1)
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [SLOT_BITS-1:0]  slot,
    input logic [SLOT_BITS-1:0]  rank,
    input logic                  evicted,
    input logic [COUNT_BITS-1:0] fill_count
);
    import rpt_pkg::*;

    localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(CAPACITY);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result withdrawn before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("new request taken while one is still in work");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fill_count != '0) && (fill_count <= CAP)
                         && ({1'b0, rank} < fill_count))
        else $error("fill count or rank out of range");

    a_grow_at_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !evicted |-> fill_count == {1'b0, slot} + COUNT_BITS'(1))
        else $error("table grew at a slot other than its fill count");

endmodule

bind ranked_population_table_unit rpt_checker #(
    .CAPACITY   (CAPACITY),
    .SLOT_BITS  (SLOT_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_rpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .slot         (result.slot),
    .rank         (result.rank),
    .evicted      (result.evicted),
    .fill_count   (result.fill_count)
);
